// ----- src/brl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

    // coordinate width; the delta and error widths below follow from it
    localparam int COORD_BITS  = 16;
    localparam int DX_BITS     = COORD_BITS + 1;
    localparam int DY_BITS     = COORD_BITS + 2;
    localparam int ERR_BITS    = COORD_BITS + 3;

    localparam int COLOR_BITS  = 32;
    localparam int DIM_BITS    = 13;
    localparam int STRIDE_BITS = 14;
    localparam int ADDR_BITS   = 25;
    localparam int PROD_BITS   = DIM_BITS + STRIDE_BITS;
    localparam int CMP_BITS    = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = ADDR_BITS + COLOR_BITS + 2 * COORD_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    // configuration port
    localparam int APB_DATA_BITS = 32;
    localparam int PADDR_BITS    = 4;
    localparam int REG_IDX_BITS  = PADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_ROW_STRIDE    = REG_IDX_BITS'(2);

    localparam logic [DIM_BITS-1:0]    RESET_WIDTH  = DIM_BITS'(1024);
    localparam logic [DIM_BITS-1:0]    RESET_HEIGHT = DIM_BITS'(768);
    localparam logic [STRIDE_BITS-1:0] RESET_STRIDE = STRIDE_BITS'(1024);

    // item kinds
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // command queue between front and back, depth a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    typedef struct packed {
        logic                          is_start;
        logic signed [COORD_BITS-1:0]  x0;
        logic signed [COORD_BITS-1:0]  y0;
        logic signed [COORD_BITS-1:0]  x1;
        logic signed [COORD_BITS-1:0]  y1;
        logic [DX_BITS-1:0]            dx_abs;
        logic signed [DY_BITS-1:0]     dy_neg;
        logic                          step_x_neg;
        logic                          step_y_neg;
        logic signed [ERR_BITS-1:0]    err;
        logic [COLOR_BITS-1:0]         color;
    } brl_cmd_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]    width;
        logic [DIM_BITS-1:0]    height;
        logic [STRIDE_BITS-1:0] stride;
    } brl_cfg_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]          addr;
        logic [COLOR_BITS-1:0]         color;
        logic                          we;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic                          last;
    } brl_pix_t;

endpackage

`default_nettype wire

// ----- src/brl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brl_front import brl_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_DATA_BITS-1:0] s_tdata,
    input  logic                    s_tuser,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output brl_cmd_t                cmd
);

    logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
    logic signed [DX_BITS-1:0]    diff_x, diff_y;
    logic                         x_ge, y_ge;
    logic [DX_BITS-1:0]           dx_abs, dy_abs;
    logic [DY_BITS-1:0]           dy_neg;
    brl_cmd_t                     cmd_next;
    logic                         valid_reg, valid_next;
    brl_cmd_t                     cmd_reg;
    logic                         load;

    assign x0 = s_tdata[COORD_BITS-1:0];
    assign y0 = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x1 = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign y1 = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    // deltas and directions worked out for every item; the back uses them on a start
    always_comb begin
        diff_x = $signed({x1[COORD_BITS-1], x1}) - $signed({x0[COORD_BITS-1], x0});
        diff_y = $signed({y1[COORD_BITS-1], y1}) - $signed({y0[COORD_BITS-1], y0});
        x_ge   = (x1 >= x0);
        y_ge   = (y1 >= y0);
        dx_abs = x_ge ? diff_x : -diff_x;
        dy_abs = y_ge ? diff_y : -diff_y;
        dy_neg = DY_BITS'(0) - {1'b0, dy_abs};

        cmd_next            = '0;
        cmd_next.is_start   = (s_tuser == FUNC_START);
        cmd_next.x0         = x0;
        cmd_next.y0         = y0;
        cmd_next.x1         = x1;
        cmd_next.y1         = y1;
        cmd_next.dx_abs     = dx_abs;
        cmd_next.dy_neg     = dy_neg;
        cmd_next.step_x_neg = !(x0 < x1);
        cmd_next.step_y_neg = !(y0 < y1);
        cmd_next.err        = {2'b00, dx_abs} + {dy_neg[DY_BITS-1], dy_neg};
        cmd_next.color      = s_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
    end

    assign s_tready = !valid_reg || cmd_ready;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// ----- src/brl_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brl_queue import brl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  brl_cmd_t in_cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output brl_cmd_t out_cmd
);

    brl_cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic                   push, pop;

    assign in_ready  = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/brl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brl_back import brl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  brl_cfg_t cfg,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  brl_cmd_t cmd,
    output logic     pix_valid,
    input  logic     pix_ready,
    output brl_pix_t pix
);

    // line state
    logic                         active_reg, active_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_BITS-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [DX_BITS-1:0]           dx_reg, dx_next;
    logic signed [DY_BITS-1:0]    dy_reg, dy_next;
    logic                         sxn_reg, sxn_next, syn_reg, syn_next;
    logic signed [ERR_BITS-1:0]   err_reg, err_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;

    // pixel stage
    logic                         a_valid_reg, a_valid_next;
    logic                         a_pix_reg;
    logic signed [COORD_BITS-1:0] a_x_reg, a_y_reg;
    logic [COLOR_BITS-1:0]        a_color_reg;
    logic                         a_last_reg;

    // output stage
    logic                         b_valid_reg, b_valid_next;
    brl_pix_t                     b_pix_reg, b_pix_next;

    logic                         adv_a, adv_b, take;
    logic signed [ERR_BITS:0]     e2, dy_ext, dx_ext;
    logic                         go_x, go_y;
    logic [ERR_BITS-1:0]          add_x, add_y;
    logic signed [COORD_BITS-1:0] step_x, step_y;
    logic                         produce, at_end, last_flag;

    logic [CMP_BITS-1:0]          x_ext, y_ext;
    logic                         on_screen;
    logic [PROD_BITS-1:0]         prod, sum;

    assign adv_b     = !b_valid_reg || pix_ready;
    assign adv_a     = !a_valid_reg || adv_b;
    assign cmd_ready = adv_a;
    assign take      = cmd_valid && adv_a;

    // one bresenham update per cycle while an item is taken; a held output stalls it
    always_comb begin
        e2     = $signed({err_reg, 1'b0});
        dy_ext = $signed({{(ERR_BITS + 1 - DY_BITS){dy_reg[DY_BITS-1]}}, dy_reg});
        dx_ext = $signed({{(ERR_BITS + 1 - DX_BITS){1'b0}}, dx_reg});
        go_x   = (e2 >= dy_ext);
        go_y   = (e2 <= dx_ext);
        add_x  = go_x ? dy_ext[ERR_BITS-1:0] : '0;
        add_y  = go_y ? dx_ext[ERR_BITS-1:0] : '0;
        step_x = sxn_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
        step_y = syn_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);

        cx_next = cx_reg;  cy_next = cy_reg;
        tx_next = tx_reg;  ty_next = ty_reg;
        dx_next = dx_reg;  dy_next = dy_reg;
        sxn_next = sxn_reg; syn_next = syn_reg;
        err_next = err_reg; color_next = color_reg;

        if (cmd.is_start) begin
            cx_next    = cmd.x0;
            cy_next    = cmd.y0;
            tx_next    = cmd.x1;
            ty_next    = cmd.y1;
            dx_next    = cmd.dx_abs;
            dy_next    = cmd.dy_neg;
            sxn_next   = cmd.step_x_neg;
            syn_next   = cmd.step_y_neg;
            err_next   = cmd.err;
            color_next = cmd.color;
        end else if (active_reg) begin
            err_next = err_reg + add_x + add_y;
            if (go_x) begin
                cx_next = cx_reg + step_x;
            end
            if (go_y) begin
                cy_next = cy_reg + step_y;
            end
        end

        produce     = cmd.is_start || active_reg;
        at_end      = (cx_next == tx_next) && (cy_next == ty_next);
        last_flag   = produce ? at_end : 1'b1;
        active_next = produce ? !at_end : active_reg;
    end

    assign a_valid_next = take ? 1'b1 : (adv_b ? 1'b0 : a_valid_reg);

    // clip, then y * stride + x
    always_comb begin
        x_ext     = CMP_BITS'($unsigned(a_x_reg));
        y_ext     = CMP_BITS'($unsigned(a_y_reg));
        on_screen = a_pix_reg && !a_x_reg[COORD_BITS-1] && !a_y_reg[COORD_BITS-1]
                    && (x_ext < CMP_BITS'(cfg.width)) && (y_ext < CMP_BITS'(cfg.height));
        prod      = y_ext[DIM_BITS-1:0] * cfg.stride;
        sum       = prod + PROD_BITS'(x_ext[DIM_BITS-1:0]);

        b_pix_next       = '0;
        b_pix_next.addr  = on_screen ? sum[ADDR_BITS-1:0] : '0;
        b_pix_next.color = a_pix_reg ? a_color_reg : '0;
        b_pix_next.we    = on_screen;
        b_pix_next.x     = a_pix_reg ? a_x_reg : '0;
        b_pix_next.y     = a_pix_reg ? a_y_reg : '0;
        b_pix_next.last  = a_last_reg;
    end

    assign b_valid_next = adv_b ? a_valid_reg : b_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            tx_reg      <= '0;
            ty_reg      <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            sxn_reg     <= 1'b0;
            syn_reg     <= 1'b0;
            err_reg     <= '0;
            color_reg   <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                active_reg <= active_next;
                cx_reg     <= cx_next;
                cy_reg     <= cy_next;
                tx_reg     <= tx_next;
                ty_reg     <= ty_next;
                dx_reg     <= dx_next;
                dy_reg     <= dy_next;
                sxn_reg    <= sxn_next;
                syn_reg    <= syn_next;
                err_reg    <= err_next;
                color_reg  <= color_next;
            end
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
        if (take) begin
            a_pix_reg   <= produce;
            a_x_reg     <= cx_next;
            a_y_reg     <= cy_next;
            a_color_reg <= color_next;
            a_last_reg  <= last_flag;
        end
        if (adv_b && a_valid_reg) begin
            b_pix_reg <= b_pix_next;
        end
    end

    assign pix_valid = b_valid_reg;
    assign pix       = b_pix_reg;

endmodule

`default_nettype wire

// ----- src/bresenham_line_rasterizer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Line rasterizer: a start item (tuser 0) loads both endpoints and the color and
// returns the first endpoint; each step item (tuser 1) moves one pixel along the
// line and returns it. Every result carries the framebuffer word address
// y * row_stride_words + x (low 25 bits), the color, a write enable that is low
// for pixels off screen (address then reads 0), the coordinates, and tlast on
// the end point. A step with no line in progress returns an all-zero result
// with tlast high. One item is taken and one result leaves per clock while
// m_tready is high; the back end's error-term update is combinational.
// From input to output an item passes the input register, the two-entry
// command queue, the line stepper and the address multiply stage.
// Screen size and stride are written over the register port; the user must
// do so only while no item is in flight, as the block does not enforce it.
module bresenham_line_rasterizer import brl_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,

    // start_x, start_y, end_x, end_y, pixel_color (from bit 0 up)
    input  logic [IN_DATA_BITS-1:0]    s_tdata,
    // func
    input  logic                       s_tuser,
    input  logic                       s_tvalid,
    output logic                       s_tready,

    // pixel_address, write_color, pixel_x, pixel_y, zero fill (from bit 0 up)
    output logic [OUT_DATA_BITS-1:0]   m_tdata,
    // write_enable
    output logic                       m_tuser,
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_BITS-1:0]      paddr,
    input  logic [APB_DATA_BITS-1:0]   pwdata,
    output logic [APB_DATA_BITS-1:0]   prdata,
    output logic                       pready
);

    // configuration registers
    logic [DIM_BITS-1:0]     width_reg, width_next;
    logic [DIM_BITS-1:0]     height_reg, height_next;
    logic [STRIDE_BITS-1:0]  stride_reg, stride_next;
    logic                    cfg_write;
    logic [REG_IDX_BITS-1:0] reg_idx;
    brl_cfg_t                cfg;

    // front to queue, queue to back
    logic                    f_valid, f_ready;
    brl_cmd_t                f_cmd;
    logic                    q_valid, q_ready;
    brl_cmd_t                q_cmd;
    logic                    out_valid;
    brl_pix_t                out_pix;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        stride_next = stride_reg;
        if (cfg_write) begin
            case (reg_idx)
                REG_SCREEN_WIDTH:  width_next  = pwdata[DIM_BITS-1:0];
                REG_SCREEN_HEIGHT: height_next = pwdata[DIM_BITS-1:0];
                REG_ROW_STRIDE:    stride_next = pwdata[STRIDE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SCREEN_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_SCREEN_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
            REG_ROW_STRIDE:    prdata = APB_DATA_BITS'(stride_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            stride_reg <= RESET_STRIDE;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            stride_reg <= stride_next;
        end
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.stride = stride_reg;

    // front: takes items, works out deltas for starts
    brl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    // short queue so front and back stall independently
    brl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // back: line stepper, clipping, address, output register
    brl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .pix_valid (out_valid),
        .pix_ready (m_tready),
        .pix       (out_pix)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = out_pix.we;
    assign m_tlast  = out_pix.last;
    assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, out_pix.y, out_pix.x,
                       out_pix.color, out_pix.addr};

    // a written pixel never has a negative coordinate
    a_we_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !out_pix.x[COORD_BITS-1] && !out_pix.y[COORD_BITS-1])
        else $error("write enable on a negative coordinate");

    // clipped or empty results carry a zero address
    a_clip_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> out_pix.addr == '0)
        else $error("nonzero address without write enable");

    // nothing leaves the block right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
